// ===== design/mexp_pkg.sv =====
// Shared constants and types for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

  // Width of a residue modulo the prime.
  localparam int unsigned ValW = 30;
  // Default exponent width.
  localparam int unsigned ExpWidth = 63;

  // The prime modulus and its double, used by the final correction step.
  localparam logic [ValW-1:0] Modulus      = 30'd1000000007;
  localparam logic [ValW+1:0] TwiceModulus = 32'd2000000014;

  // Barrett constant floor(2^60 / p), which fits in 31 bits.
  localparam logic [63:0]   MuFull    = 64'h1000_0000_0000_0000 / 64'd1000000007;
  localparam logic [ValW:0] BarrettMu = MuFull[ValW:0];

  // Destination of a multiplier result: the running square or the accumulator.
  typedef enum logic {
    TAG_SQ,
    TAG_ACC
  } mexp_tag_e;

  // Control that travels alongside an operation through the multiplier.
  typedef struct packed {
    logic      valid;
    mexp_tag_e tag;
  } mexp_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_MUL,
    ST_WAIT,
    ST_DONE
  } mexp_state_e;

endpackage

`default_nettype wire

// ===== design/mexp_modmul.sv =====
// Four-stage pipelined modular multiplier with Barrett reduction.
`default_nettype none

module mexp_modmul (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire mexp_pkg::mexp_op_t              op_i,
  input  wire logic [mexp_pkg::ValW-1:0]       a_i,
  input  wire logic [mexp_pkg::ValW-1:0]       b_i,
  output mexp_pkg::mexp_op_t                   res_o,
  output logic [mexp_pkg::ValW-1:0]            res_val_o
);

  localparam int unsigned W  = mexp_pkg::ValW;
  localparam int unsigned PW = 2 * W;

  logic [3:0]              vld_q;
  mexp_pkg::mexp_tag_e     tag_q [4];

  logic [PW-1:0]           prod_q;
  logic [PW+1:0]           est_q;
  logic [W+1:0]            xlo_q;
  logic [W+1:0]            rem_q;
  logic [W-1:0]            res_q;

  logic [PW+1:0]           est_d;
  logic [PW:0]             qp;
  logic [W:0]              quo;
  logic [W-1:0]            res_d;

  // Estimate of the quotient from the upper product bits.
  assign est_d = {{(W+1){1'b0}}, prod_q[PW-1:W-1]} * {{(W+1){1'b0}}, mexp_pkg::BarrettMu};
  assign quo   = est_q[PW+1:W+1];
  assign qp    = {{W{1'b0}}, quo} * {{(W+1){1'b0}}, mexp_pkg::Modulus};

  // The estimate is at most two short, so the remainder is below 3p.
  always_comb begin
    if (rem_q >= mexp_pkg::TwiceModulus) begin
      res_d = W'(rem_q - mexp_pkg::TwiceModulus);
    end else if (rem_q >= {2'b00, mexp_pkg::Modulus}) begin
      res_d = W'(rem_q - {2'b00, mexp_pkg::Modulus});
    end else begin
      res_d = rem_q[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], op_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= op_i.tag;
    tag_q[1] <= tag_q[0];
    tag_q[2] <= tag_q[1];
    tag_q[3] <= tag_q[2];
    prod_q   <= {{W{1'b0}}, a_i} * {{W{1'b0}}, b_i};
    est_q    <= est_d;
    xlo_q    <= prod_q[W+1:0];
    rem_q    <= xlo_q - qp[W+1:0];
    res_q    <= res_d;
  end

  assign res_o.valid = vld_q[3];
  assign res_o.tag   = tag_q[3];
  assign res_val_o   = res_q;

endmodule

`default_nettype wire

// ===== design/modular_exponentiation.sv =====
// Top level: right-to-left square-and-multiply exponentiation modulo 1000000007.
// Per exponent bit the sequencer issues a square and, when the bit is set, an accumulator
// multiply, then waits for the last of them to return from the four-stage multiplier.
// One item at a time: the next item is accepted only after the result has moved into the
// output register.
// Reset (rst_ni, asynchronous, active low) clears the sequencer and all valid flags only.
`default_nettype none

module modular_exponentiation #(
  parameter int unsigned ExpW = mexp_pkg::ExpWidth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input item stream.
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // Bits from low up: base (30), exponent (ExpW), zero padding to whole bytes.
  input  wire logic [((mexp_pkg::ValW+ExpW+7)/8)*8-1:0] s_axis_tdata_i,
  // Result item stream.
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // Bits from low up: power (30), zero padding to whole bytes.
  output logic [((mexp_pkg::ValW+7)/8)*8-1:0]           m_axis_tdata_o
);

  localparam int unsigned W      = mexp_pkg::ValW;
  localparam int unsigned MDataW = ((W + 7) / 8) * 8;

  mexp_pkg::mexp_state_e state_q, state_d;

  // Running square, accumulator and the not yet scanned exponent bits.
  logic [W-1:0]    sq_q, sq_d;
  logic [W-1:0]    acc_q, acc_d;
  logic [ExpW-1:0] exp_q, exp_d;
  // Set when the current bit also issued an accumulator multiply.
  logic            mul_q, mul_d;

  // Output register, which lets a finished result wait for the consumer.
  logic            m_valid_q, m_valid_d;
  logic [W-1:0]    m_data_q, m_data_d;

  mexp_pkg::mexp_op_t op;
  mexp_pkg::mexp_op_t res;
  logic [W-1:0]       op_a;
  logic [W-1:0]       res_val;

  logic [W-1:0]       base_in;
  logic [W-1:0]       base_red;

  assign base_in  = s_axis_tdata_i[W-1:0];
  // A 30-bit base is below 2p, so one conditional subtraction reduces it.
  assign base_red = (base_in >= mexp_pkg::Modulus) ? (base_in - mexp_pkg::Modulus) : base_in;

  // The square uses sq*sq; the accumulator update uses acc*sq.
  assign op_a = (op.tag == mexp_pkg::TAG_ACC) ? acc_q : sq_q;

  mexp_modmul u_modmul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .a_i       (op_a),
    .b_i       (sq_q),
    .res_o     (res),
    .res_val_o (res_val)
  );

  always_comb begin
    state_d         = state_q;
    sq_d            = sq_q;
    acc_d           = acc_q;
    exp_d           = exp_q;
    mul_d           = mul_q;
    op.valid        = 1'b0;
    op.tag          = mexp_pkg::TAG_SQ;
    s_axis_tready_o = 1'b0;
    m_valid_d       = m_valid_q && !m_axis_tready_i;
    m_data_d        = m_data_q;

    // Multiplier results land in the register named by their tag.
    if (res.valid) begin
      if (res.tag == mexp_pkg::TAG_SQ) begin
        sq_d = res_val;
      end else begin
        acc_d = res_val;
      end
    end

    case (state_q)
      mexp_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          sq_d    = base_red;
          acc_d   = W'(1);
          exp_d   = s_axis_tdata_i[W+ExpW-1:W];
          state_d = mexp_pkg::ST_BIT;
        end
      end
      mexp_pkg::ST_BIT: begin
        if (exp_q == '0) begin
          state_d = mexp_pkg::ST_DONE;
        end else begin
          // Square now; a set bit also multiplies the accumulator by the old square.
          op.valid = 1'b1;
          op.tag   = mexp_pkg::TAG_SQ;
          mul_d    = exp_q[0];
          exp_d    = exp_q >> 1;
          state_d  = exp_q[0] ? mexp_pkg::ST_MUL : mexp_pkg::ST_WAIT;
        end
      end
      mexp_pkg::ST_MUL: begin
        // The square has not returned yet, so sq_q still holds the old square.
        op.valid = 1'b1;
        op.tag   = mexp_pkg::TAG_ACC;
        state_d  = mexp_pkg::ST_WAIT;
      end
      mexp_pkg::ST_WAIT: begin
        // The last operation issued for this bit closes it.
        if (res.valid &&
            (res.tag == (mul_q ? mexp_pkg::TAG_ACC : mexp_pkg::TAG_SQ))) begin
          state_d = mexp_pkg::ST_BIT;
        end
      end
      mexp_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = acc_q;
          state_d   = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mexp_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q     <= sq_d;
    acc_q    <= acc_d;
    exp_q    <= exp_d;
    mul_q    <= mul_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = MDataW'(m_data_q);

  // A delivered result is always a fully reduced residue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_data_q < mexp_pkg::Modulus))
    else $error("result not reduced below the modulus");

  // Multiplier results only come back while the sequencer waits for them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (state_q == mexp_pkg::ST_WAIT))
    else $error("multiplier result outside the wait state");

  // Operands of the multiplier are reduced whenever the sequencer scans a bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mexp_pkg::ST_BIT) |-> (sq_q < mexp_pkg::Modulus && acc_q < mexp_pkg::Modulus))
    else $error("operand not reduced");

  // Each scanned bit drops exactly one exponent bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mexp_pkg::ST_BIT && exp_q != '0) |=> (exp_q == ($past(exp_q) >> 1)))
    else $error("exponent not shifted by one bit");

endmodule

`default_nettype wire
